FILE: rtl/i2cm_pkg.sv
package i2cm_pkg;

  // command codes carried by one request
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_WRITE  = 3'd3;
  localparam logic [2:0] CMD_RD_ACK = 3'd4;
  localparam logic [2:0] CMD_RD_NAK = 3'd5;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd4;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // one-hot bus sequence steps
  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_STA_REL = 20'h00002,
    S_STA_SDA = 20'h00004,
    S_STA_SCL = 20'h00008,
    S_STO_LOW = 20'h00010,
    S_STO_SCL = 20'h00020,
    S_STO_SDA = 20'h00040,
    S_STO_END = 20'h00080,
    S_WR_BIT  = 20'h00100,
    S_WR_SCLH = 20'h00200,
    S_WR_SCLL = 20'h00400,
    S_WR_REL  = 20'h00800,
    S_WR_ACKH = 20'h01000,
    S_WR_ACKL = 20'h02000,
    S_RD_REL  = 20'h04000,
    S_RD_SCLH = 20'h08000,
    S_RD_SCLL = 20'h10000,
    S_RD_ACK  = 20'h20000,
    S_RD_ACKH = 20'h40000,
    S_RD_END  = 20'h80000
  } step_t;

  // classified request as it waits in the queue
  typedef struct packed {
    logic       has_cmd;
    step_t      first_step;
    logic [2:0] command;
    logic [7:0] write_data;
    logic       sda_in;
  } q_entry_t;

endpackage

FILE: rtl/i2cm_front.sv
module i2cm_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_command,
  input  logic [7:0]          in_write_data,
  input  logic                in_sda_in,
  input  logic                q_full,
  output logic                q_push,
  output i2cm_pkg::q_entry_t  q_entry
);
  import i2cm_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // map the command to the first step of its sequence; unused codes do nothing
  always_comb begin
    q_entry.command    = in_command;
    q_entry.write_data = in_write_data;
    q_entry.sda_in     = in_sda_in;
    q_entry.has_cmd    = 1'b1;
    q_entry.first_step = S_IDLE;
    unique case (in_command)
      CMD_START:  q_entry.first_step = S_STA_REL;
      CMD_STOP:   q_entry.first_step = S_STO_LOW;
      CMD_WRITE:  q_entry.first_step = S_WR_BIT;
      CMD_RD_ACK,
      CMD_RD_NAK: q_entry.first_step = S_RD_REL;
      default:    q_entry.has_cmd    = 1'b0;
    endcase
  end

endmodule

FILE: rtl/i2cm_queue.sv
module i2cm_queue #(
  parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  i2cm_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output i2cm_pkg::q_entry_t  head,
  output logic                full,
  output logic                empty
);
  import i2cm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/i2cm_back.sv
module i2cm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_phase_ticks,
  input  logic                q_empty,
  input  i2cm_pkg::q_entry_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_scl_out,
  output logic                out_sda_out,
  output logic                out_busy_res,
  output logic                out_done_res,
  output logic [7:0]          out_read_data,
  output logic                out_ack_received
);
  import i2cm_pkg::*;

  logic [7:0] phase_ticks_r;
  logic [7:0] phase_r, phase_nxt;
  step_t      step_r, step_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] act_r, act_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_r, ack_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       done_r, done_nxt;
  logic       valid_r;
  logic       run;
  step_t      cur;
  logic [3:0] bit_inc;

  assign cfg_ready = 1'b1;
  // engine state doubles as the result register: advance only when it is free
  assign q_pop     = !q_empty && (!valid_r || out_ready);

  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    act_nxt   = act_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    done_nxt  = 1'b0;
    run       = 1'b0;
    cur       = step_r;
    bit_inc   = bit_r + 4'd1;

    if (q_pop) begin
      if (step_r == S_IDLE) begin
        if (q_head.has_cmd) begin
          act_nxt   = q_head.command;
          bit_nxt   = '0;
          shift_nxt = (q_head.command == CMD_WRITE) ? q_head.write_data : '0;
          cur       = q_head.first_step;
          run       = 1'b1;
        end
      end else if (phase_r != '0) begin
        phase_nxt = phase_r - 8'd1;
      end else begin
        run = 1'b1;
      end
    end

    if (run) begin
      unique case (cur)
        S_STA_REL: begin
          scl_nxt = 1'b1; sda_nxt = 1'b1;
          phase_nxt = phase_ticks_r; step_nxt = S_STA_SDA;
        end
        S_STA_SDA: begin
          sda_nxt = 1'b0; phase_nxt = phase_ticks_r; step_nxt = S_STA_SCL;
        end
        S_STA_SCL: begin
          scl_nxt = 1'b0; phase_nxt = '0; step_nxt = S_IDLE; done_nxt = 1'b1;
        end
        S_STO_LOW: begin
          scl_nxt = 1'b0; sda_nxt = 1'b0;
          phase_nxt = phase_ticks_r; step_nxt = S_STO_SCL;
        end
        S_STO_SCL: begin
          scl_nxt = 1'b1; phase_nxt = phase_ticks_r; step_nxt = S_STO_SDA;
        end
        S_STO_SDA: begin
          sda_nxt = 1'b1; phase_nxt = phase_ticks_r; step_nxt = S_STO_END;
        end
        S_STO_END: begin
          phase_nxt = '0; step_nxt = S_IDLE; done_nxt = 1'b1;
        end
        S_WR_BIT: begin
          sda_nxt   = shift_nxt[7];
          shift_nxt = {shift_nxt[6:0], 1'b0};
          phase_nxt = phase_ticks_r; step_nxt = S_WR_SCLH;
        end
        S_WR_SCLH: begin
          scl_nxt = 1'b1; phase_nxt = phase_ticks_r; step_nxt = S_WR_SCLL;
        end
        S_WR_SCLL: begin
          scl_nxt   = 1'b0;
          bit_nxt   = bit_inc;
          phase_nxt = '0;
          step_nxt  = bit_inc[3] ? S_WR_REL : S_WR_BIT;
        end
        S_WR_REL: begin
          sda_nxt = 1'b1; phase_nxt = phase_ticks_r; step_nxt = S_WR_ACKH;
        end
        S_WR_ACKH: begin
          scl_nxt = 1'b1; ack_nxt = !q_head.sda_in;
          phase_nxt = phase_ticks_r; step_nxt = S_WR_ACKL;
        end
        S_WR_ACKL: begin
          scl_nxt = 1'b0; phase_nxt = '0; step_nxt = S_IDLE; done_nxt = 1'b1;
        end
        S_RD_REL: begin
          sda_nxt = 1'b1; phase_nxt = phase_ticks_r; step_nxt = S_RD_SCLH;
        end
        S_RD_SCLH: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], q_head.sda_in};
          phase_nxt = phase_ticks_r; step_nxt = S_RD_SCLL;
        end
        S_RD_SCLL: begin
          scl_nxt = 1'b0;
          bit_nxt = bit_inc;
          if (bit_inc[3]) begin
            phase_nxt = '0; step_nxt = S_RD_ACK;
          end else begin
            phase_nxt = phase_ticks_r; step_nxt = S_RD_SCLH;
          end
        end
        S_RD_ACK: begin
          sda_nxt = (act_r != CMD_RD_ACK);
          phase_nxt = phase_ticks_r; step_nxt = S_RD_ACKH;
        end
        S_RD_ACKH: begin
          scl_nxt = 1'b1; phase_nxt = phase_ticks_r; step_nxt = S_RD_END;
        end
        S_RD_END: begin
          scl_nxt = 1'b0; rx_nxt = shift_r;
          phase_nxt = '0; step_nxt = S_IDLE; done_nxt = 1'b1;
        end
        default: begin
          phase_nxt = '0; step_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
      phase_r       <= '0;
      step_r        <= S_IDLE;
      bit_r         <= '0;
      shift_r       <= '0;
      act_r         <= CMD_NONE;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      ack_r         <= 1'b0;
      rx_r          <= '0;
      done_r        <= 1'b0;
      valid_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        phase_ticks_r <= cfg_phase_ticks;
      end
      if (q_pop) begin
        phase_r <= phase_nxt;
        step_r  <= step_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        act_r   <= act_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        ack_r   <= ack_nxt;
        rx_r    <= rx_nxt;
        done_r  <= done_nxt;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_scl_out      = scl_r;
  assign out_sda_out      = sda_r;
  assign out_busy_res     = (step_r != S_IDLE);
  assign out_done_res     = done_r;
  assign out_read_data    = rx_r;
  assign out_ack_received = ack_r;

endmodule

FILE: rtl/i2c_master_byte_engine.sv
// Path: an accepted request is written into the queue, then popped by the back
// end into the sequencer registers, which hold the result until it is taken.
// Throughput: one tick request per clock cycle unless the result side stalls;
// the queue absorbs output stalls.
// Reset (rst_n low, synchronous): queue emptied, sequencer idle, SCL and SDA
// released high, phase_ticks back to 4, received byte and ACK flag cleared.
module i2c_master_byte_engine #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_phase_ticks,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_command,
  input  logic [7:0] in_write_data,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_data,
  output logic       out_ack_received
);
  import i2cm_pkg::*;

  q_entry_t q_in_entry;
  q_entry_t q_head;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  // Front end: take each tick request, decode its command into the first
  // sequence step and drop unused codes to "no command".
  i2cm_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_write_data (in_write_data),
    .in_sda_in     (in_sda_in),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_in_entry)
  );

  // Short queue: lets the front keep accepting, until it is full, while the result side stalls.
  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Back end: the bus sequencer. Advance one tick per popped request; its
  // line, flag and byte registers hold the result until it is taken.
  i2cm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_phase_ticks  (cfg_phase_ticks),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_out      (out_scl_out),
    .out_sda_out      (out_sda_out),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_data    (out_read_data),
    .out_ack_received (out_ack_received)
  );

  // A completing tick always leaves the sequencer idle.
  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while sequence still busy");

  // The back end never draws from an empty queue.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A request taken at the front is waiting in the queue on the next cycle.
  a_push_lands : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !q_empty)
    else $error("accepted request missing from queue");

endmodule
